>>> rtl/pbps_pkg.sv
// ----------------------------------------------------------------------------
// pbps_pkg: controller bus packet sequencer shared types
// Op codes, configuration indexes, reset values and the result word layout.
// ----------------------------------------------------------------------------
package pbps_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_ACK   = 3'd2;
  localparam logic [2:0] OP_RECV  = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;

  localparam logic [1:0] CFG_SELECT_DELAY = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_PORT_TWO     = 2'd2;

  localparam logic [9:0] SELECT_DELAY_RESET = 10'd60;
  localparam logic [9:0] ACK_TIMEOUT_RESET  = 10'd120;
  localparam logic [9:0] TICK_MAX           = 10'd1023;
  localparam logic [8:0] COUNT_MAX          = 9'd511;

  typedef struct packed {
    logic       select_line;
    logic       port_select;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       finished;
    logic [8:0] reply_count;
    logic       busy_res;
  } result_t;

endpackage

>>> rtl/pbps_if.sv
// ----------------------------------------------------------------------------
// pbps_if: item and result channels
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface pbps_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_byte;
  logic [8:0] request_length;
  logic [8:0] max_response;

  modport source (output valid, op, data_byte, request_length, max_response, input ready);
  modport sink (input valid, op, data_byte, request_length, max_response, output ready);
endinterface

interface pbps_result_if;
  logic       valid;
  logic       ready;
  logic       select_line;
  logic       port_select;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       finished;
  logic [8:0] reply_count;
  logic       busy_res;

  modport source (output valid, select_line, port_select, send_valid, send_byte,
                  reply_valid, reply_byte, finished, reply_count, busy_res,
                  input ready);
  modport sink (input valid, select_line, port_select, send_valid, send_byte,
                reply_valid, reply_byte, finished, reply_count, busy_res,
                output ready);
endinterface

>>> rtl/pbps_out_reg.sv
// ----------------------------------------------------------------------------
// pbps_out_reg: result output register
// Holds one result word until the sink takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module pbps_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  output logic              free,
  input  pbps_pkg::result_t word,
  pbps_result_if.source     result
);

  logic              full;
  pbps_pkg::result_t held;

  assign free = !full || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= word;
    end
  end

  assign result.valid       = full;
  assign result.select_line = held.select_line;
  assign result.port_select = held.port_select;
  assign result.send_valid  = held.send_valid;
  assign result.send_byte   = held.send_byte;
  assign result.reply_valid = held.reply_valid;
  assign result.reply_byte  = held.reply_byte;
  assign result.finished    = held.finished;
  assign result.reply_count = held.reply_count;
  assign result.busy_res    = held.busy_res;

endmodule

>>> rtl/pad_bus_packet_sequencer.sv
// ----------------------------------------------------------------------------
// pad_bus_packet_sequencer: controller bus packet sequencer, master side
// Buffers request bytes, runs select, address, acknowledge and byte exchange
// phases on tick, acknowledge and receive events, and reports the reply count.
// ----------------------------------------------------------------------------
// channel   dir   handshake      word
// item      in    valid/ready    op, data_byte, request_length, max_response
// result    out   valid/ready    select_line .. busy_res, one per item
// wr_*      in    wr_en only     select_delay_us, ack_timeout_us, port_two
//
// One item per cycle while the output register is free; each result is
// registered and appears in the cycle after its item. The request buffer is
// read ahead at the next send index, so a request byte is ready on the cycle
// its acknowledge arrives. Synchronous reset; the request buffer keeps its
// contents over reset. A stalled result holds in the output register;
// item.ready falls only while that register is full and not taken.
// ----------------------------------------------------------------------------
module pad_bus_packet_sequencer #(
  parameter int REQUEST_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [9:0]  wr_data,
  pbps_item_if.sink   item,
  pbps_result_if.source result
);

  localparam int IDX_W  = $clog2(REQUEST_DEPTH);
  localparam int LEFT_W = $clog2(REQUEST_DEPTH + 1);
  localparam int CMP_W  = (LEFT_W > 9) ? LEFT_W : 9;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SELWAIT, PH_ADDRACK, PH_XFER, PH_BYTEACK, PH_ENDWAIT
  } phase_t;

  logic [9:0] select_delay_us;
  logic [9:0] ack_timeout_us;
  logic       port_two;

  phase_t             phase, phase_next;
  logic [9:0]         tick_count, tick_count_next;
  logic               ack_latched, ack_latched_next;
  logic [IDX_W-1:0]   load_pointer, load_pointer_next;
  logic [IDX_W-1:0]   send_index, send_index_next;
  logic [LEFT_W-1:0]  request_left, request_left_next;
  logic [8:0]         reply_total, reply_total_next;
  logic [8:0]         reply_limit, reply_limit_next;
  logic [7:0]         address_hold, address_hold_next;

  logic [7:0]         req_mem [REQUEST_DEPTH];
  logic [7:0]         rd_data;
  logic               mem_we;

  logic               fire;
  logic               out_free;
  pbps_pkg::result_t  word;

  logic               chk, ends;
  logic [9:0]         tick_inc;

  assign item.ready = out_free;
  assign fire       = item.valid && out_free;
  assign tick_inc   = (tick_count == pbps_pkg::TICK_MAX) ? tick_count : tick_count + 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_delay_us <= pbps_pkg::SELECT_DELAY_RESET;
      ack_timeout_us  <= pbps_pkg::ACK_TIMEOUT_RESET;
      port_two        <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        pbps_pkg::CFG_SELECT_DELAY: select_delay_us <= wr_data;
        pbps_pkg::CFG_ACK_TIMEOUT:  ack_timeout_us  <= wr_data;
        pbps_pkg::CFG_PORT_TWO:     port_two        <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    ack_latched_next  = ack_latched;
    load_pointer_next = load_pointer;
    send_index_next   = send_index;
    request_left_next = request_left;
    reply_total_next  = reply_total;
    reply_limit_next  = reply_limit;
    address_hold_next = address_hold;
    mem_we            = 1'b0;
    chk               = 1'b0;
    ends              = 1'b0;
    word              = '0;

    if (fire) begin
      case (item.op)
        pbps_pkg::OP_START: begin
          if (phase == PH_IDLE) begin
            address_hold_next = item.data_byte;
            request_left_next = (CMP_W'(item.request_length) > CMP_W'(REQUEST_DEPTH))
                                ? LEFT_W'(REQUEST_DEPTH) : LEFT_W'(item.request_length);
            reply_limit_next  = item.max_response;
            reply_total_next  = '0;
            send_index_next   = '0;
            load_pointer_next = '0;
            ack_latched_next  = 1'b0;
            phase_next        = PH_SELWAIT;
            tick_count_next   = '0;
            if (select_delay_us == '0) begin
              word.send_valid = 1'b1;
              word.send_byte  = item.data_byte;
              phase_next      = PH_ADDRACK;
              chk             = 1'b1;
            end
          end
        end
        pbps_pkg::OP_TICK: begin
          if (phase == PH_SELWAIT) begin
            tick_count_next = tick_inc;
            if (tick_inc >= select_delay_us) begin
              word.send_valid = 1'b1;
              word.send_byte  = address_hold;
              phase_next      = PH_ADDRACK;
              tick_count_next = '0;
              chk             = 1'b1;
            end
          end else if (phase == PH_ADDRACK || phase == PH_BYTEACK) begin
            tick_count_next = tick_inc;
            if (tick_inc >= ack_timeout_us) begin
              ends = 1'b1;
            end
          end else if (phase == PH_ENDWAIT) begin
            tick_count_next = tick_inc;
            if (tick_inc >= select_delay_us) begin
              phase_next    = PH_IDLE;
              word.finished = 1'b1;
            end
          end
        end
        pbps_pkg::OP_ACK: begin
          ack_latched_next = 1'b1;
          if (phase == PH_ADDRACK || phase == PH_BYTEACK) begin
            chk = 1'b1;
          end
        end
        pbps_pkg::OP_RECV: begin
          if (phase == PH_XFER) begin
            word.reply_valid = 1'b1;
            word.reply_byte  = item.data_byte;
            if (reply_total != pbps_pkg::COUNT_MAX) begin
              reply_total_next = reply_total + 9'd1;
            end
            phase_next      = PH_BYTEACK;
            tick_count_next = '0;
            chk             = 1'b1;
          end
        end
        pbps_pkg::OP_LOAD: begin
          if (phase == PH_IDLE) begin
            mem_we            = 1'b1;
            load_pointer_next = (load_pointer == IDX_W'(REQUEST_DEPTH - 1))
                                ? '0 : load_pointer + 1'b1;
          end
        end
        default: ;
      endcase

      if (chk) begin
        if (ack_timeout_us == '0) begin
          ends = 1'b1;
        end else if (ack_latched_next) begin
          ack_latched_next = 1'b0;
          if (reply_total_next < reply_limit_next) begin
            word.send_valid = 1'b1;
            if (request_left_next != '0) begin
              word.send_byte    = rd_data;
              request_left_next = request_left_next - 1'b1;
              send_index_next   = (send_index_next == IDX_W'(REQUEST_DEPTH - 1))
                                  ? '0 : send_index_next + 1'b1;
            end else begin
              word.send_byte = '0;
            end
            phase_next = PH_XFER;
          end else begin
            ends = 1'b1;
          end
        end
      end

      if (ends) begin
        phase_next      = PH_ENDWAIT;
        tick_count_next = '0;
        if (select_delay_us == '0) begin
          phase_next    = PH_IDLE;
          word.finished = 1'b1;
        end
      end
    end

    word.select_line = (phase_next != PH_IDLE);
    word.busy_res    = (phase_next != PH_IDLE);
    word.port_select = port_two;
    word.reply_count = reply_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      ack_latched  <= 1'b0;
      load_pointer <= '0;
      send_index   <= '0;
      request_left <= '0;
      reply_total  <= '0;
      reply_limit  <= '0;
      address_hold <= '0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      ack_latched  <= ack_latched_next;
      load_pointer <= load_pointer_next;
      send_index   <= send_index_next;
      request_left <= request_left_next;
      reply_total  <= reply_total_next;
      reply_limit  <= reply_limit_next;
      address_hold <= address_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      req_mem[load_pointer] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && load_pointer == send_index_next) begin
      rd_data <= item.data_byte;
    end else begin
      rd_data <= req_mem[send_index_next];
    end
  end

  pbps_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .free   (out_free),
    .word   (word),
    .result (result)
  );

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result.valid)
    else $error("accepted item produced no result word");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && item.op == pbps_pkg::OP_START && phase == PH_IDLE &&
     select_delay_us != '0) |=> phase != PH_IDLE)
    else $error("start in idle did not begin a packet");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid && $stable(result.send_byte) &&
      $stable(result.reply_byte) && $stable(result.reply_count))
    else $error("stalled result word changed");

  a_finished_released: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.finished) |-> !result.select_line && !result.busy_res)
    else $error("finished word with select still asserted");
`endif

endmodule
